// ----- hdl/ecc_pkg.sv -----
// Shared types and constants of the elevator car controller.
// Holds the command and event codes, the result run struct and queue sizes.
// Depends on nothing; imported by the top level, ecc_core and ecc_rsp_queue.
package ecc_pkg;

   // Default number of floors served by one car.
   localparam int ECC_FLOORS = 16;

   // Dwell length after reset, in ticks.
   localparam logic [15:0] DWELL_RESET = 16'd5000;

   // One event causes at most this many commands.
   localparam int RUN_MAX = 4;
   localparam int RUN_AW  = $clog2(RUN_MAX);
   localparam int RUN_CW  = $clog2(RUN_MAX + 1);

   // Result queue: a power of two, at least twice a full run.
   localparam int RSP_DEPTH = 8;
   localparam int RSP_AW    = $clog2(RSP_DEPTH);
   localparam int RSP_CW    = $clog2(RSP_DEPTH + 1);

   // Commands sent to the car.
   typedef enum logic [2:0] {
      CMD_READY    = 3'd0,
      CMD_CLOSE    = 3'd1,
      CMD_OPEN     = 3'd2,
      CMD_STOP     = 3'd3,
      CMD_UP       = 3'd4,
      CMD_DOWN     = 3'd5,
      CMD_LAMP_ON  = 3'd6,
      CMD_LAMP_OFF = 3'd7
   } cmd_type;

   // Decoded input events.
   typedef enum logic [2:0] {
      EVT_TICK   = 3'd0,
      EVT_FLOOR  = 3'd1,
      EVT_OPENED = 3'd2,
      EVT_CLOSED = 3'd3,
      EVT_HALL   = 3'd4,
      EVT_CAR    = 3'd5
   } evt_type;

   // One command with its lamp floor.
   typedef struct packed {
      cmd_type     cmd;
      logic [3:0]  lamp;
   } rsp_item_type;

   // All commands caused by one event, in order.
   typedef struct packed {
      logic [RUN_CW-1:0]           count;
      rsp_item_type [RUN_MAX-1:0]  item;
   } run_type;

endpackage

// ----- hdl/elevator_car_controller.sv -----
// Top level of the elevator car controller: input register, dwell register,
// event logic and result queue. Depends on ecc_pkg, ecc_core and ecc_rsp_queue.

// An accepted event is registered, handled by the event logic in the next cycle
// and its commands enter an eight-entry result queue, so the first command of an
// event passes the input register and a queue slot before it appears. Events
// that cause no command can follow one a cycle while the result queue is empty;
// an event may cause up to four commands, and the result channel sends one beat
// a cycle unless rsp_stall holds it. The stall check does not credit the beat
// leaving in the same cycle. req_stall rises while the queue lacks room for a
// full run from the event in the input register plus a full run from a new
// event. The dwell register resets to 5000 ticks and is written through the csr
// channel; the user must write it only while the block is idle, as the block
// does not enforce it.
module elevator_car_controller import ecc_pkg::*; #(
   parameter int FLOORS = ECC_FLOORS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [3:0]  req_floor_number,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_command,
   output logic [3:0]  rsp_lamp_floor,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_dwell_ticks
);

   logic              in_valid_ff, in_valid_in;
   logic [2:0]        in_type_ff;
   logic [3:0]        in_floor_ff;
   logic [15:0]       dwell_ticks_ff;
   logic [RSP_CW-1:0] rsp_count;
   logic [RSP_CW:0]   room_sum;
   logic              req_accept;
   run_type           run;

   // Stall while the queue could not take the event in flight plus a new one.
   assign room_sum   = (RSP_CW + 1)'(rsp_count) +
                       (in_valid_ff ? (RSP_CW + 1)'(RUN_MAX) : '0);
   assign req_stall  = reset || (room_sum > (RSP_CW + 1)'(RSP_DEPTH - RUN_MAX));
   assign req_accept = req_valid && !req_stall;
   assign in_valid_in = req_accept;
   assign csr_ready  = !reset;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_type_ff  <= req_type;
         in_floor_ff <= req_floor_number;
      end
   end

   // Dwell length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         dwell_ticks_ff <= DWELL_RESET;
      end else if (csr_valid && csr_ready) begin
         dwell_ticks_ff <= csr_dwell_ticks;
      end
   end

   ecc_core #(
      .FLOORS (FLOORS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (in_valid_ff),
      .in_type     (in_type_ff),
      .in_floor    (in_floor_ff),
      .dwell_ticks (dwell_ticks_ff),
      .run         (run)
   );

   ecc_rsp_queue u_rsp_queue (
      .clock           (clock),
      .reset           (reset),
      .run             (run),
      .count           (rsp_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_command     (rsp_command),
      .rsp_lamp_floor  (rsp_lamp_floor),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ----- hdl/ecc_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the pending floor FIFO; depends on nothing.
module ecc_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; a read sees the old data on a collision.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/ecc_core.sv -----
// Event logic of the elevator car controller: car state, pending FIFO and dwell.
// Turns one registered event into a run of up to four commands combinationally.
// Depends on ecc_pkg and ecc_ram.
module ecc_core import ecc_pkg::*; #(
   parameter int FLOORS = ECC_FLOORS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [2:0]  in_type,
   input  logic [3:0]  in_floor,
   input  logic [15:0] dwell_ticks,
   output run_type     run
);

   localparam int FW = $clog2(FLOORS);
   localparam int CW = $clog2(FLOORS + 1);

   logic [FW-1:0]     cur_ff, cur_in;
   logic [FW-1:0]     target_ff, target_in;
   logic              moving_ff, moving_in;
   logic              door_ff, door_in;
   logic              started_ff, started_in;
   logic [FLOORS-1:0] marks_ff, marks_in;
   logic [FW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              dwelling_ff, dwelling_in;
   logic [15:0]       dwell_left_ff, dwell_left_in;
   logic              bypass_ff;
   logic [FW-1:0]     bypass_data_ff;

   logic              wr_en;
   logic [FW-1:0]     wr_addr;
   logic [FW-1:0]     rd_data;
   logic [FW-1:0]     head_value;
   logic [FW:0]       tail_sum;
   logic [FW-1:0]     floor_v;
   logic              floor_ok;
   run_type           run_v;

   // Adds one command to the end of a run.
   function automatic run_type append(run_type r, cmd_type c, logic [3:0] l);
      run_type o;
      o = r;
      if (r.count < RUN_CW'(RUN_MAX)) begin
         o.item[r.count[RUN_AW-1:0]].cmd  = c;
         o.item[r.count[RUN_AW-1:0]].lamp = l;
         o.count = r.count + RUN_CW'(1);
      end
      return o;
   endfunction

   // Pending floor FIFO storage.
   ecc_ram #(
      .WIDTH (FW),
      .DEPTH (FLOORS)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (floor_v),
      .rd_addr (head_in),
      .rd_data (rd_data)
   );

   // The RAM read is registered; a write to the new head slot is forwarded.
   assign head_value = bypass_ff ? bypass_data_ff : rd_data;

   // Tail slot of the FIFO, wrapped at the floor count.
   assign tail_sum = {1'b0, head_ff} + (FW + 1)'(count_ff);
   assign wr_addr  = (tail_sum >= (FW + 1)'(FLOORS)) ?
                     FW'(tail_sum - (FW + 1)'(FLOORS)) : FW'(tail_sum);

   assign floor_ok = int'(in_floor) < FLOORS;
   assign floor_v  = FW'(in_floor);

   // Event decode and next state.
   always_comb begin
      cur_in        = cur_ff;
      target_in     = target_ff;
      moving_in     = moving_ff;
      door_in       = door_ff;
      started_in    = started_ff;
      marks_in      = marks_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      dwelling_in   = dwelling_ff;
      dwell_left_in = dwell_left_ff;
      wr_en         = 1'b0;
      run_v         = '0;

      if (in_valid) begin
         if (!started_ff) begin
            started_in = 1'b1;
            run_v = append(run_v, CMD_READY, 4'd0);
         end

         case (in_type)
            EVT_TICK: begin
               if (dwelling_ff) begin
                  if (dwell_left_ff > 16'd1) begin
                     dwell_left_in = dwell_left_ff - 16'd1;
                  end else begin
                     // Dwell is over: serve the oldest pending floor, if any.
                     dwelling_in   = 1'b0;
                     dwell_left_in = 16'd0;
                     if (count_ff != '0) begin
                        head_in  = (head_ff == FW'(FLOORS - 1)) ? '0 : head_ff + FW'(1);
                        count_in = count_ff - CW'(1);
                        marks_in[head_value] = 1'b0;
                        target_in = head_value;
                        if (head_value != cur_ff) begin
                           moving_in = 1'b1;
                           run_v = append(run_v, CMD_CLOSE, 4'd0);
                           run_v = append(run_v, (head_value > cur_ff) ? CMD_UP : CMD_DOWN,
                                          4'd0);
                        end
                     end
                  end
               end
            end
            EVT_FLOOR: begin
               if (floor_ok) begin
                  cur_in = floor_v;
                  // Arrival at the target floor.
                  if (moving_ff && floor_v == target_ff) begin
                     moving_in = 1'b0;
                     run_v = append(run_v, CMD_STOP, 4'd0);
                     run_v = append(run_v, CMD_LAMP_OFF, 4'(floor_v));
                     if (!door_ff) begin
                        marks_in[floor_v] = 1'b0;
                        run_v = append(run_v, CMD_OPEN, 4'd0);
                     end
                     dwelling_in   = 1'b1;
                     dwell_left_in = dwell_ticks;
                  end
               end
            end
            EVT_OPENED: begin
               door_in = 1'b1;
            end
            EVT_CLOSED: begin
               door_in = 1'b0;
            end
            EVT_HALL, EVT_CAR: begin
               if (floor_ok) begin
                  if (moving_ff || dwelling_ff) begin
                     // Busy: queue the floor unless it is already pending.
                     if (!marks_ff[floor_v] && count_ff < CW'(FLOORS)) begin
                        wr_en = 1'b1;
                        marks_in[floor_v] = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end else begin
                     target_in = floor_v;
                     if (floor_v != cur_ff) begin
                        moving_in = 1'b1;
                        run_v = append(run_v, CMD_CLOSE, 4'd0);
                        run_v = append(run_v, (floor_v > cur_ff) ? CMD_UP : CMD_DOWN, 4'd0);
                     end
                  end
                  if (in_type == EVT_CAR && cur_ff != target_in) begin
                     run_v = append(run_v, CMD_LAMP_ON, in_floor);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign run = run_v;

   // Car state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff         <= '0;
         target_ff      <= '0;
         moving_ff      <= 1'b0;
         door_ff        <= 1'b0;
         started_ff     <= 1'b0;
         marks_ff       <= '0;
         head_ff        <= '0;
         count_ff       <= '0;
         dwelling_ff    <= 1'b0;
         dwell_left_ff  <= 16'd0;
         bypass_ff      <= 1'b0;
         bypass_data_ff <= '0;
      end else begin
         cur_ff         <= cur_in;
         target_ff      <= target_in;
         moving_ff      <= moving_in;
         door_ff        <= door_in;
         started_ff     <= started_in;
         marks_ff       <= marks_in;
         head_ff        <= head_in;
         count_ff       <= count_in;
         dwelling_ff    <= dwelling_in;
         dwell_left_ff  <= dwell_left_in;
         bypass_ff      <= wr_en && (wr_addr == head_in);
         bypass_data_ff <= floor_v;
      end
   end

   // The car never travels while it dwells at a stop.
   a_move_or_dwell: assert property (@(posedge clock) disable iff (reset)
      !(moving_ff && dwelling_ff))
      else $error("car moving while dwelling");

   // The pending FIFO never holds more floors than there are.
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(FLOORS))
      else $error("pending FIFO count out of range");

   // A dwell always starts with the configured length.
   a_dwell_load: assert property (@(posedge clock) disable iff (reset)
      (!dwelling_ff && dwelling_in) |=> (dwell_left_ff == $past(dwell_ticks)))
      else $error("dwell counter not loaded");

endmodule

// ----- hdl/ecc_rsp_queue.sv -----
// Result queue of the elevator car controller.
// Takes a run of up to four commands at once and hands out one beat a cycle while rsp_stall is low.
// Depends on ecc_pkg.
module ecc_rsp_queue import ecc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  run_type           run,
   output logic [RSP_CW-1:0] count,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_command,
   output logic [3:0]        rsp_lamp_floor,
   output logic              rsp_last_of_run
);

   typedef struct packed {
      rsp_item_type item;
      logic         last;
   } entry_type;

   entry_type         entries_ff [RSP_DEPTH];
   entry_type         entries_in [RSP_DEPTH];
   logic [RSP_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CW-1:0] count_ff, count_in;
   logic              pop;

   assign pop = rsp_valid && !rsp_stall;

   // Write the run into consecutive slots; the last command carries the flag.
   always_comb begin
      logic [RSP_AW-1:0] idx;
      entries_in = entries_ff;
      idx        = wr_ptr_ff;
      for (int i = 0; i < RUN_MAX; i++) begin
         idx = wr_ptr_ff + RSP_AW'(i);
         if (RUN_CW'(i) < run.count) begin
            entries_in[idx].item = run.item[i];
            entries_in[idx].last = (RUN_CW'(i) == run.count - RUN_CW'(1));
         end
      end
      wr_ptr_in = wr_ptr_ff + RSP_AW'(run.count);
      rd_ptr_in = rd_ptr_ff + RSP_AW'(pop);
      count_in  = count_ff + RSP_CW'(run.count) - RSP_CW'(pop);
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

   assign count           = count_ff;
   assign rsp_valid       = count_ff != '0;
   assign rsp_command     = entries_ff[rd_ptr_ff].item.cmd;
   assign rsp_lamp_floor  = entries_ff[rd_ptr_ff].item.lamp;
   assign rsp_last_of_run = entries_ff[rd_ptr_ff].last;

   // A pushed run always fits in the free slots.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ((RSP_CW + 1)'(count_ff) + (RSP_CW + 1)'(run.count)) <= (RSP_CW + 1)'(RSP_DEPTH))
      else $error("result queue overflow");

endmodule
